/* rtl/mvm_pkg.sv */
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, constants and binary32 arithmetic for the matrix-vector unit.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int LANES      = 8;
    localparam int MAX_COLS   = 4096;
    localparam int MAX_ROWS   = 4096;
    localparam int GROUPS_MAX = MAX_COLS / LANES;
    localparam int GRP_W      = $clog2(GROUPS_MAX);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int NROWS_W    = 13;
    localparam int NCG_W      = 10;
    localparam int FP_W       = 32;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int NORM_STEPS = ROW_W;
    localparam int STEP_W     = $clog2(NORM_STEPS);

    localparam logic REG_NUM_ROWS       = 1'b0;
    localparam logic REG_NUM_COL_GROUPS = 1'b1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_MATRIX = 1'b1;

    localparam logic [FP_W-1:0] FP_POS_ZERO    = 32'h0000_0000;
    localparam logic [FP_W-1:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

    typedef logic [LANES-1:0][FP_W-1:0] lane_vec_t;

    typedef struct packed {
        logic             first;
        logic             emit;
        logic [ROW_W-1:0] row_idx;
        logic             last_row;
    } mvm_ctl_t;

    function automatic logic fp_is_nan(input logic [31:0] v);
        fp_is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] v);
        fp_is_inf = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    // Rounds a significand with the hidden bit at [26], guard at [2], round
    // at [1] and sticky at [0], handling underflow into the subnormal range.
    function automatic logic [31:0] fp_round_pack(input logic s,
                                                  input logic signed [11:0] e,
                                                  input logic [26:0] sig);
        logic [26:0]        sg;
        logic signed [11:0] ex;
        logic [11:0]        sh;
        logic [26:0]        mask;
        logic               inc;
        logic [24:0]        m;
        logic [31:0]        r;
        sg = sig;
        ex = e;
        if (ex < 12'sd1)
        begin
            sh = 12'(12'sd1 - ex);
            if (sh > 12'd26)
                sg = {26'd0, |sig};
            else
            begin
                mask = ~(27'h7FF_FFFF << sh[4:0]);
                sg   = (sig >> sh[4:0]) | {26'd0, |(sig & mask)};
            end
            ex = 12'sd0;
        end
        inc = sg[2] & (sg[1] | sg[0] | sg[3]);
        m   = {1'b0, sg[26:3]} + {24'd0, inc};
        if (ex == 12'sd0)
            r = {s, 7'd0, m[23], m[22:0]};
        else
        begin
            if (m[24])
            begin
                m  = m >> 1;
                ex = ex + 12'sd1;
            end
            if (ex >= 12'sd255)
                r = {s, 8'hFF, 23'd0};
            else
                r = {s, ex[7:0], m[22:0]};
        end
        fp_round_pack = r;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        p;
        logic [47:0]        n;
        logic [5:0]         lz;
        logic signed [11:0] e;
        logic [31:0]        r;
        s  = a[31] ^ b[31];
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p  = ma * mb;
        lz = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (p[i])
                lz = 6'(47 - i);
        end
        n = p << lz;
        e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
        if (fp_is_nan(a))
            r = a | 32'h0040_0000;
        else if (fp_is_nan(b))
            r = b | 32'h0040_0000;
        else if ((fp_is_inf(a) && (b[30:0] == 31'd0)) || (fp_is_inf(b) && (a[30:0] == 31'd0)))
            r = FP_DEFAULT_NAN;
        else if (fp_is_inf(a) || fp_is_inf(b))
            r = {s, 8'hFF, 23'd0};
        else if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0))
            r = {s, 31'd0};
        else
            r = fp_round_pack(s, e, {n[47:24], n[23], n[22], |n[21:0]});
        fp_mul = r;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        x;
        logic [31:0]        y;
        logic [7:0]         ex;
        logic [7:0]         ey;
        logic [7:0]         d;
        logic [26:0]        mx;
        logic [26:0]        my;
        logic [26:0]        mya;
        logic [26:0]        mask;
        logic [27:0]        sum;
        logic [26:0]        sg;
        logic [4:0]         lz;
        logic signed [11:0] e;
        logic [31:0]        r;
        if (a[30:0] >= b[30:0])
        begin
            x = a;
            y = b;
        end
        else
        begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {x[30:23] != 8'd0, x[22:0], 3'b000};
        my = {y[30:23] != 8'd0, y[22:0], 3'b000};
        d  = ex - ey;
        if (d > 8'd26)
            mya = {26'd0, |my};
        else
        begin
            mask = ~(27'h7FF_FFFF << d[4:0]);
            mya  = (my >> d[4:0]) | {26'd0, |(my & mask)};
        end
        if (x[31] ^ y[31])
            sum = {1'b0, mx} - {1'b0, mya};
        else
            sum = {1'b0, mx} + {1'b0, mya};
        e  = $signed({4'd0, ex});
        lz = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (sum[i])
                lz = 5'(26 - i);
        end
        if (sum[27])
        begin
            sg = sum[27:1] | {26'd0, sum[0]};
            e  = e + 12'sd1;
        end
        else
        begin
            sg = sum[26:0] << lz;
            e  = e - $signed({7'd0, lz});
        end
        if (fp_is_nan(a))
            r = a | 32'h0040_0000;
        else if (fp_is_nan(b))
            r = b | 32'h0040_0000;
        else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]))
            r = FP_DEFAULT_NAN;
        else if (fp_is_inf(a))
            r = a;
        else if (fp_is_inf(b))
            r = b;
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            r = {a[31] & b[31], 31'd0};
        else if (a[30:0] == 31'd0)
            r = b;
        else if (b[30:0] == 31'd0)
            r = a;
        else if (sum == 28'd0)
            r = FP_POS_ZERO;
        else
            r = fp_round_pack(x[31], e, sg);
        fp_add = r;
    endfunction

endpackage

/* rtl/mvm_ram.sv */
// ----------------------------------------------------------------------------
// mvm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mvm_ctrl.sv */
// ----------------------------------------------------------------------------
// mvm_ctrl
// Configuration registers and the load, column and row counters.
// ----------------------------------------------------------------------------
module mvm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mvm_pkg::PADDR_W-1:0]    paddr,
    input  logic [mvm_pkg::PDATA_W-1:0]    pwdata,
    output logic [mvm_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           fire,
    input  logic                           func,
    output logic                           busy,
    output logic [mvm_pkg::GRP_W-1:0]      ram_addr,
    output mvm_pkg::mvm_ctl_t              issue_ctl
);
    import mvm_pkg::*;

    logic [NROWS_W-1:0] num_rows_reg;
    logic [NCG_W-1:0]   num_col_groups_reg;
    logic [GRP_W-1:0]   load_group_reg, load_group_next;
    logic [GRP_W-1:0]   col_group_reg, col_group_next;
    logic [ROW_W-1:0]   row_count_reg, row_count_next;
    logic [GRP_W-1:0]   load_group_raw_reg, load_group_raw_next;
    logic [GRP_W-1:0]   col_group_raw_reg, col_group_raw_next;
    logic [ROW_W-1:0]   row_count_raw_reg, row_count_raw_next;
    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [NCG_W-1:0]   groups_eff;
    logic [NROWS_W-1:0] rows_eff;
    logic               wr_en;
    logic               load_last;
    logic               col_last;
    logic               row_last;
    logic [23:0]        grp_div;
    logic [23:0]        row_div;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        if (num_col_groups_reg == '0)
            groups_eff = NCG_W'(1);
        else if (num_col_groups_reg > NCG_W'(GROUPS_MAX))
            groups_eff = NCG_W'(GROUPS_MAX);
        else
            groups_eff = num_col_groups_reg;
        if (num_rows_reg == '0)
            rows_eff = NROWS_W'(1);
        else if (num_rows_reg > NROWS_W'(MAX_ROWS))
            rows_eff = NROWS_W'(MAX_ROWS);
        else
            rows_eff = num_rows_reg;
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NUM_ROWS:       prdata = PDATA_W'(num_rows_reg);
            REG_NUM_COL_GROUPS: prdata = PDATA_W'(num_col_groups_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg       <= NROWS_W'(1);
            num_col_groups_reg <= NCG_W'(1);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_NUM_ROWS:       num_rows_reg       <= pwdata[NROWS_W-1:0];
                REG_NUM_COL_GROUPS: num_col_groups_reg <= pwdata[NCG_W-1:0];
                default:            ;
            endcase
        end
    end

    assign load_last = ({1'b0, load_group_reg} + NCG_W'(1)) == groups_eff;
    assign col_last  = ({1'b0, col_group_reg} + NCG_W'(1)) == groups_eff;
    assign row_last  = ({1'b0, row_count_reg} + NROWS_W'(1)) == rows_eff;

    assign issue_ctl.first    = (col_group_reg == '0);
    assign issue_ctl.emit     = col_last;
    assign issue_ctl.row_idx  = row_count_reg;
    assign issue_ctl.last_row = row_last;
    assign ram_addr = (func == FUNC_LOAD) ? load_group_reg : col_group_reg;
    assign busy     = busy_reg;

    // After a register write the working counters are rebuilt from the values
    // the last transaction left, then reduced modulo the current sizes by
    // shift-and-subtract, one divisor multiple per cycle.
    assign grp_div = 24'(groups_eff) << step_reg;
    assign row_div = 24'(rows_eff) << step_reg;

    always_comb
    begin
        load_group_next     = load_group_reg;
        col_group_next      = col_group_reg;
        row_count_next      = row_count_reg;
        load_group_raw_next = load_group_raw_reg;
        col_group_raw_next  = col_group_raw_reg;
        row_count_raw_next  = row_count_raw_reg;
        busy_next           = busy_reg;
        step_next           = step_reg;
        priority if (wr_en)
        begin
            load_group_next = load_group_raw_reg;
            col_group_next  = col_group_raw_reg;
            row_count_next  = row_count_raw_reg;
            busy_next       = 1'b1;
            step_next       = STEP_W'(NORM_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (24'(load_group_reg) >= grp_div)
                load_group_next = load_group_reg - grp_div[GRP_W-1:0];
            if (24'(col_group_reg) >= grp_div)
                col_group_next = col_group_reg - grp_div[GRP_W-1:0];
            if (24'(row_count_reg) >= row_div)
                row_count_next = row_count_reg - row_div[ROW_W-1:0];
            if (step_reg == '0)
                busy_next = 1'b0;
            else
                step_next = step_reg - STEP_W'(1);
        end
        else if (fire)
        begin
            if (func == FUNC_LOAD)
            begin
                load_group_next = load_last ? '0 : load_group_reg + GRP_W'(1);
                col_group_next  = '0;
                row_count_next  = '0;
            end
            else
            begin
                load_group_next = '0;
                if (col_last)
                begin
                    col_group_next = '0;
                    row_count_next = row_last ? '0 : row_count_reg + ROW_W'(1);
                end
                else
                    col_group_next = col_group_reg + GRP_W'(1);
            end
            load_group_raw_next = load_group_next;
            col_group_raw_next  = col_group_next;
            row_count_raw_next  = row_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_group_reg     <= '0;
            col_group_reg      <= '0;
            row_count_reg      <= '0;
            load_group_raw_reg <= '0;
            col_group_raw_reg  <= '0;
            row_count_raw_reg  <= '0;
            busy_reg           <= 1'b0;
            step_reg           <= '0;
        end
        else
        begin
            load_group_reg     <= load_group_next;
            col_group_reg      <= col_group_next;
            row_count_reg      <= row_count_next;
            load_group_raw_reg <= load_group_raw_next;
            col_group_raw_reg  <= col_group_raw_next;
            row_count_raw_reg  <= row_count_raw_next;
            busy_reg           <= busy_next;
            step_reg           <= step_next;
        end
    end

endmodule

/* rtl/mvm_mac.sv */
// ----------------------------------------------------------------------------
// mvm_mac
// Lane multipliers, an eight-stage ordered adder chain and the row accumulator.
// ----------------------------------------------------------------------------
module mvm_mac (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_vld,
    input  mvm_pkg::mvm_ctl_t        in_ctl,
    input  mvm_pkg::lane_vec_t       a_lanes,
    input  mvm_pkg::lane_vec_t       x_lanes,
    output logic                     tail_vld,
    output mvm_pkg::mvm_ctl_t        tail_ctl,
    output logic [mvm_pkg::FP_W-1:0] acc_sum
);
    import mvm_pkg::*;

    // Stage 0 holds the products; stage j adds product j-1 to the partial sum.
    logic      [LANES:0] vld_reg;
    mvm_ctl_t            ctl_reg  [LANES+1];
    lane_vec_t           prod_reg [LANES];
    logic [FP_W-1:0]     sum_reg  [LANES];
    logic [FP_W-1:0]     acc_reg;
    logic [FP_W-1:0]     acc_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LANES-1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= in_ctl;
            for (int k = 0; k < LANES; k++)
                prod_reg[0][k] <= fp_mul(a_lanes[k], x_lanes[k]);
            sum_reg[0] <= fp_add(FP_POS_ZERO, prod_reg[0][0]);
            for (int j = 1; j <= LANES; j++)
                ctl_reg[j] <= ctl_reg[j-1];
            for (int j = 1; j < LANES; j++)
            begin
                prod_reg[j] <= prod_reg[j-1];
                sum_reg[j]  <= fp_add(sum_reg[j-1], prod_reg[j][j]);
            end
        end
    end

    assign tail_vld = vld_reg[LANES];
    assign tail_ctl = ctl_reg[LANES];
    assign acc_in   = tail_ctl.first ? FP_POS_ZERO : acc_reg;
    assign acc_sum  = fp_add(acc_in, sum_reg[LANES-1]);

    always_ff @(posedge clk)
    begin
        if (adv && tail_vld)
            acc_reg <= acc_sum;
    end

endmodule

/* rtl/matrix_vector_multiply_f32.sv */
// ----------------------------------------------------------------------------
// matrix_vector_multiply_f32
// Dense binary32 matrix-vector multiply, eight lanes per transaction.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle, loads and matrix groups
// alike. For a matrix group the vector memory is read and the matrix lanes
// are registered at the accepting edge; then the eight lane multipliers
// register their products, the lane-ordered adder chain sums them in lane
// order, and the row accumulator add feeds the output register. The
// accumulator loop holds no register but its own, which lets groups of one
// row follow back to back. The input stalls only while a finished row waits
// at the output behind a stalled consumer, and after each register write
// while the counters are reduced to the new matrix size.
module matrix_vector_multiply_f32 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mvm_pkg::PADDR_W-1:0]    paddr,
    input  logic [mvm_pkg::PDATA_W-1:0]    pwdata,
    output logic [mvm_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [31:0]                    lane_0,
    input  logic [31:0]                    lane_1,
    input  logic [31:0]                    lane_2,
    input  logic [31:0]                    lane_3,
    input  logic [31:0]                    lane_4,
    input  logic [31:0]                    lane_5,
    input  logic [31:0]                    lane_6,
    input  logic [31:0]                    lane_7,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    y_value,
    output logic [mvm_pkg::ROW_W-1:0]      row_index,
    output logic                           last_row
);
    import mvm_pkg::*;

    lane_vec_t            lanes_in;
    lane_vec_t            x_lanes;
    lane_vec_t            s1_a_reg;
    mvm_ctl_t             s1_ctl_reg;
    logic                 s1_vld_reg;
    mvm_ctl_t             issue_ctl;
    mvm_ctl_t             tail_ctl;
    logic                 tail_vld;
    logic [FP_W-1:0]      acc_sum;
    logic [GRP_W-1:0]     ram_addr;
    logic                 busy;
    logic                 adv;
    logic                 fire;
    logic                 out_vld_reg, out_vld_next;
    logic [FP_W-1:0]      y_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 last_reg;

    assign lanes_in = {lane_7, lane_6, lane_5, lane_4, lane_3, lane_2, lane_1, lane_0};

    // A finished row that cannot leave holds the whole pipeline; anything
    // else moves on.
    assign adv      = !(tail_vld && tail_ctl.emit && out_vld_reg && out_stall);
    assign in_stall = busy || !adv;
    assign fire     = in_valid && !in_stall;

    mvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fire      (fire),
        .func      (func),
        .busy      (busy),
        .ram_addr  (ram_addr),
        .issue_ctl (issue_ctl)
    );

    mvm_ram #(
        .WIDTH (LANES * FP_W),
        .DEPTH (GROUPS_MAX)
    ) u_vec_ram (
        .clk   (clk),
        .we    (fire && (func == FUNC_LOAD)),
        .re    (fire && (func == FUNC_MATRIX)),
        .addr  (ram_addr),
        .wdata (lanes_in),
        .rdata (x_lanes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= fire && (func == FUNC_MATRIX);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg   <= lanes_in;
            s1_ctl_reg <= issue_ctl;
        end
    end

    mvm_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s1_vld_reg),
        .in_ctl   (s1_ctl_reg),
        .a_lanes  (s1_a_reg),
        .x_lanes  (x_lanes),
        .tail_vld (tail_vld),
        .tail_ctl (tail_ctl),
        .acc_sum  (acc_sum)
    );

    always_comb
    begin
        if (adv && tail_vld && tail_ctl.emit)
            out_vld_next = 1'b1;
        else if (!out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && tail_vld && tail_ctl.emit)
        begin
            y_reg    <= acc_sum;
            row_reg  <= tail_ctl.row_idx;
            last_reg <= tail_ctl.last_row;
        end
    end

    assign out_valid = out_vld_reg;
    assign y_value   = y_reg;
    assign row_index = row_reg;
    assign last_row  = last_reg;

endmodule

/* sim/tb_matrix_vector_multiply_f32.sv */
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply_f32
// Self-checking bench for the binary32 matrix-vector unit. Vector loads and
// matrix groups are fed under random idling on both channels (one phase
// runs with no idling) across several register settings. A scoreboard
// predicts every finished row and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class mvm_scoreboard;

    typedef struct {
        logic [31:0] y;
        logic [11:0] row;
        logic        last;
    } row_result_t;

    logic [31:0]   vec_mem [4096];
    int unsigned   load_grp;
    int unsigned   col_grp;
    int unsigned   row_cnt;
    logic [31:0]   row_sum;
    logic [12:0]   cfg_rows;
    logic [9:0]    cfg_groups;
    row_result_t   pending[$];
    int            errors;

    function new();
        load_grp   = 0;
        col_grp    = 0;
        row_cnt    = 0;
        row_sum    = 32'h0;
        cfg_rows   = 13'd1;
        cfg_groups = 10'd1;
        errors     = 0;
    endfunction

    function int unsigned active_groups();
        int unsigned g;
        g = 32'(cfg_groups);
        if (g == 0)
            g = 1;
        if (g > mvm_pkg::GROUPS_MAX)
            g = mvm_pkg::GROUPS_MAX;
        return g;
    endfunction

    function int unsigned active_rows();
        int unsigned r;
        r = 32'(cfg_rows);
        if (r == 0)
            r = 1;
        if (r > mvm_pkg::MAX_ROWS)
            r = mvm_pkg::MAX_ROWS;
        return r;
    endfunction

    static function real pow2(int n);
        return $bitstoreal({1'b0, 11'(1023 + n), 52'd0});
    endfunction

    static function real f32_to_real(logic [31:0] b);
        real v;
        if (b[30:23] == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, 52'd0});
        if (b[30:0] == 31'd0)
            return $bitstoreal({b[31], 63'd0});
        if (b[30:23] == 8'd0)
            v = real'(b[22:0]) * pow2(-149);
        else
            v = real'({1'b1, b[22:0]}) * pow2(int'(b[30:23]) - 150);
        return b[31] ? -v : v;
    endfunction

    // Rounds an exact double to binary32, nearest even, with gradual underflow.
    static function logic [31:0] real_to_f32(real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        int          e;
        int          sh;
        logic        half;
        logic        sticky;
        d = $realtobits(r);
        if (d[62:52] == 11'd0)
            return {d[63], 31'd0};
        if (d[62:52] == 11'h7FF)
            return {d[63], 8'hFF, 23'd0};
        e   = int'(d[62:52]) - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = 29 + ((e < -126) ? (-126 - e) : 0);
        if (sh > 60)
            return {d[63], 31'd0};
        kept   = sig >> sh;
        half   = sig[sh-1];
        sticky = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
        kept   = kept + ((half && (sticky || kept[0])) ? 64'd1 : 64'd0);
        if (e < -126)
            return {d[63], kept[30:0]};
        if (kept[24])
        begin
            kept = kept >> 1;
            e    = e + 1;
        end
        if (e > 127)
            return {d[63], 8'hFF, 23'd0};
        return {d[63], 8'(e + 127), kept[22:0]};
    endfunction

    static function logic is_nan(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    static function logic is_inf(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    static function logic [31:0] times(logic [31:0] a, logic [31:0] b);
        if (is_nan(a))
            return a | 32'h0040_0000;
        if (is_nan(b))
            return b | 32'h0040_0000;
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
            return 32'hFFC0_0000;
        return real_to_f32(f32_to_real(a) * f32_to_real(b));
    endfunction

    static function logic [31:0] plus(logic [31:0] a, logic [31:0] b);
        if (is_nan(a))
            return a | 32'h0040_0000;
        if (is_nan(b))
            return b | 32'h0040_0000;
        if (is_inf(a) && is_inf(b) && a[31] != b[31])
            return 32'hFFC0_0000;
        return real_to_f32(f32_to_real(a) + f32_to_real(b));
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
        if (idx == mvm_pkg::REG_NUM_ROWS)
            cfg_rows = value[12:0];
        else
            cfg_groups = value[9:0];
    endfunction

    function void note_input(logic fn, mvm_pkg::lane_vec_t lanes);
        int unsigned g;
        int unsigned r;
        logic [31:0] partial;
        row_result_t res;
        g = (fn == mvm_pkg::FUNC_LOAD) ? load_grp % active_groups()
                                       : col_grp % active_groups();
        if (fn == mvm_pkg::FUNC_LOAD)
        begin
            for (int k = 0; k < 8; k++)
                vec_mem[(g * 8 + k) % 4096] = lanes[k];
            load_grp = (g + 1 >= active_groups()) ? 0 : g + 1;
            col_grp  = 0;
            row_cnt  = 0;
            return;
        end
        r        = row_cnt % active_rows();
        load_grp = 0;
        partial  = 32'h0;
        for (int k = 0; k < 8; k++)
            partial = plus(partial, times(lanes[k], vec_mem[(g * 8 + k) % 4096]));
        row_sum = plus((g == 0) ? 32'h0 : row_sum, partial);
        if (g + 1 >= active_groups())
        begin
            res.y    = row_sum;
            res.row  = r[11:0];
            res.last = (r + 1 >= active_rows());
            pending.push_back(res);
            col_grp = 0;
            row_cnt = res.last ? 0 : r + 1;
        end
        else
            col_grp = g + 1;
    endfunction

    function void check_result(logic [31:0] y, logic [11:0] row, logic last);
        row_result_t exp_res;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result y=%h row=%0d last=%b", $realtime, y, row, last);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        if (y !== exp_res.y)
        begin
            $display("%0t: y_value expected %h actual %h", $realtime, exp_res.y, y);
            errors++;
        end
        if (row !== exp_res.row)
        begin
            $display("%0t: row_index expected %0d actual %0d", $realtime, exp_res.row, row);
            errors++;
        end
        if (last !== exp_res.last)
        begin
            $display("%0t: last_row expected %b actual %b", $realtime, exp_res.last, last);
            errors++;
        end
    endfunction

endclass

module tb_matrix_vector_multiply_f32;

    import mvm_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic                 func;
    lane_vec_t            lanes;
    logic                 out_valid;
    logic                 out_stall;
    logic [31:0]          y_value;
    logic [ROW_W-1:0]     row_index;
    logic                 last_row;

    mvm_scoreboard        sb;
    logic                 no_idle;
    int                   quiet_cycles;

    matrix_vector_multiply_f32 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .lane_0    (lanes[0]),
        .lane_1    (lanes[1]),
        .lane_2    (lanes[2]),
        .lane_3    (lanes[3]),
        .lane_4    (lanes[4]),
        .lane_5    (lanes[5]),
        .lane_6    (lanes[6]),
        .lane_7    (lanes[7]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .y_value   (y_value),
        .row_index (row_index),
        .last_row  (last_row)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
        out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 21);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(y_value, row_index, last_row);
    end

    // Ends a hung run: counts cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] rand_f32();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v[30:23] = 8'($urandom_range(100, 154));
            6:                v = $urandom;
            7:
            begin
                case ($urandom_range(0, 4))
                    0: v[30:0] = 31'd0;
                    1: v[30:0] = {8'hFF, 23'd0};
                    2: v[30:23] = 8'hFF;
                    3: v[30:0] = {8'hFE, 23'h7F_FFFF};
                    default: v[30:0] = 31'd1;
                endcase
            end
            8:       v[30:23] = 8'd0;
            default: v[30:23] = 8'($urandom_range(240, 254));
        endcase
        return v;
    endfunction

    task automatic reg_write(logic idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic send_item(logic fn, lane_vec_t data);
        while (!no_idle && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        lanes    <= data;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(fn, data);
    endtask

    task automatic send_random(logic fn);
        lane_vec_t data;
        for (int k = 0; k < LANES; k++)
            data[k] = rand_f32();
        send_item(fn, data);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Loads a whole vector, then feeds complete rows, with a few stray
    // loads and matrix groups mixed in; the last row is always finished.
    task automatic run_matrix(int rows_to_send, int noise_pct);
        int groups;
        groups = int'(sb.active_groups());
        for (int g = 0; g < groups; g++)
            send_random(FUNC_LOAD);
        for (int r = 0; r < rows_to_send; r++)
        begin
            for (int g = 0; g < groups; g++)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                    send_random(1'($urandom_range(0, 1)));
                send_random(FUNC_MATRIX);
            end
        end
        while (sb.col_grp != 0)
            send_random(FUNC_MATRIX);
    endtask

    initial
    begin
        lane_vec_t data;
        sb           = new();
        no_idle      = 1'b0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        func         = FUNC_LOAD;
        lanes        = '0;
        out_stall    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Special operands at the default size: signed zeros, infinities,
        // NaN, subnormals and the largest finite value.
        data = {32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7FC0_1234,
                32'hFF80_0000, 32'h7F80_0000, 32'h8000_0000, 32'h0000_0000};
        send_item(FUNC_LOAD, data);
        send_item(FUNC_MATRIX, data);
        send_item(FUNC_MATRIX, '0);
        send_item(FUNC_MATRIX, '1);
        send_item(FUNC_MATRIX, {8{32'h0040_0000}});
        send_item(FUNC_MATRIX, {8{32'hFF7F_FFFF}});
        send_item(FUNC_LOAD, {8{32'h3F80_0000}});
        send_item(FUNC_MATRIX, {32'h4B80_0000, 32'hCB80_0000, 32'h3F80_0000,
                                32'h3380_0000, 32'h0080_0000, 32'h8000_0001,
                                32'h7F7F_FFFF, 32'h7F7F_FFFF});
        send_item(FUNC_MATRIX, {8{32'h0080_0000}});
        for (int i = 0; i < 6; i++)
            send_random(1'($urandom_range(0, 1)));
        while (sb.col_grp != 0)
            send_random(FUNC_MATRIX);
        drain();

        reg_write(REG_NUM_ROWS, 32'd3);
        reg_write(REG_NUM_COL_GROUPS, 32'd2);
        run_matrix(4, 0);
        // Partial reload restarts the row, then the load group wraps.
        send_random(FUNC_LOAD);
        send_random(FUNC_MATRIX);
        send_random(FUNC_LOAD);
        send_random(FUNC_LOAD);
        send_random(FUNC_LOAD);
        run_matrix(3, 0);
        drain();

        reg_write(REG_NUM_ROWS, 32'd0);
        reg_write(REG_NUM_COL_GROUPS, 32'd0);
        run_matrix(5, 10);
        drain();

        reg_write(REG_NUM_ROWS, 32'd5);
        reg_write(REG_NUM_COL_GROUPS, 32'd4);
        for (int j = 0; j < 25; j++)
            run_matrix(5, 5);
        drain();

        reg_write(REG_NUM_ROWS, 32'd7);
        reg_write(REG_NUM_COL_GROUPS, 32'd3);
        no_idle = 1'b1;
        for (int j = 0; j < 8; j++)
            run_matrix(7, 5);
        no_idle = 1'b0;
        drain();

        // Row count past the maximum acts as the maximum.
        reg_write(REG_NUM_ROWS, 32'd8191);
        reg_write(REG_NUM_COL_GROUPS, 32'd1);
        run_matrix(3, 0);
        drain();

        reg_write(REG_NUM_ROWS, 32'd2);
        reg_write(REG_NUM_COL_GROUPS, 32'd40);
        run_matrix(2, 0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/mvm_pkg.sv
rtl/mvm_ram.sv
rtl/mvm_ctrl.sv
rtl/mvm_mac.sv
rtl/matrix_vector_multiply_f32.sv
sim/tb_matrix_vector_multiply_f32.sv
